>>> src/aabbct_pkg.sv
// Package for the box collision table: request and response payloads, codes
// and state encodings used by the interfaces and the top level module.
// No dependencies.
`timescale 1ns / 1ps

package aabbct_pkg;

   localparam int ID_W     = 16;
   localparam int POS_W    = 16;
   localparam int DIM_W    = 15;
   localparam int SIZE_W   = 8;

   localparam logic [SIZE_W-1:0] QUERY_SIZE_RESET = 8'd5;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_MOVE   = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_QUERY  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_COLLISION = 2'd0,
      KIND_HIT       = 2'd1,
      KIND_DONE      = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_SATURATED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_STORE,
      ST_SEARCH,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } state_type;

   typedef struct packed {
      action_type               action;
      logic [ID_W-1:0]          actor_id;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic [DIM_W-1:0]         box_width;
      logic [DIM_W-1:0]         box_height;
      logic                     is_boundary;
   } req_payload_type;

   typedef struct packed {
      kind_type                 kind;
      logic [ID_W-1:0]          moved_id;
      logic [ID_W-1:0]          hit_id;
      logic signed [POS_W-1:0]  move_dx;
      logic signed [POS_W-1:0]  move_dy;
      logic                     with_boundary;
      status_type               status;
      logic                     last;
   } rsp_payload_type;

endpackage

>>> src/aabbct_chan_if.sv
// Valid/ready channel interfaces for requests and responses of the box
// collision table. Depends on aabbct_pkg for the payload types.
`timescale 1ns / 1ps

interface aabbct_req_if import aabbct_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface aabbct_rsp_if import aabbct_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> src/aabb_collision_table.sv
// Top level of the box collision table: sequencer, registers and response
// stage. Uses aabbct_pkg, aabbct_chan_if, aabbct_table_mem, aabbct_sat_add
// and aabbct_overlap.
//
// Requests arrive on req_chan and responses leave on rsp_chan, both
// valid/ready. Each request yields zero or more collision or hit responses in
// table order, then one done response with last set and a status.
// csr_write_en/csr_write_data set the query square size (reset value 5).
// One request is in flight at a time; req_chan.ready is high only when idle.
// The single table read port delivers one entry per cycle to the search, scan
// and compaction sweeps, except while the scan holds for a stalled response,
// and the shared saturating adder forms the four box corners in turn.
// An add forms the box and stores it, or ends at once when the table is full;
// a query forms its square and scans; a move searches, forms the moved box,
// stores it and scans; a remove searches and compacts the entries above it.
// A response waits in an output register; when the receiver stalls, the
// sweep holds on the next pending hit until that register frees up.
// Reset empties the table and restores the query size; table contents are
// not cleared and need no clearing pass.
`timescale 1ns / 1ps

module aabb_collision_table import aabbct_pkg::*; #(
   parameter int TABLE_DEPTH = 32,
   parameter int COORD_BITS  = 16
) (
   input  logic              clock,
   input  logic              reset,
   aabbct_req_if.sink        req_chan,
   aabbct_rsp_if.source      rsp_chan,
   input  logic              csr_write_en,
   input  logic [SIZE_W-1:0] csr_write_data
);

   localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int ADD_W   = ((COORD_BITS > POS_W) ? COORD_BITS : POS_W) + 2;
   localparam int OWN_LSB = 4 * COORD_BITS;
   localparam int BND_BIT = OWN_LSB + ID_W;
   localparam int ENTRY_W = BND_BIT + 1;

   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]            stg_idx_ff, stg_idx_in;
   logic                        stg_vld_ff, stg_vld_in;
   logic [IDX_W-1:0]            found_ff, found_in;
   logic [1:0]                  step_ff, step_in;
   logic                        sat_ff, sat_in;
   status_type                  status_ff, status_in;
   logic [SIZE_W-1:0]           size_ff, size_in;
   req_payload_type             req_ff, req_in;
   logic signed [COORD_BITS-1:0] box_ff [4];
   logic signed [COORD_BITS-1:0] box_in [4];
   logic                        mbnd_ff, mbnd_in;
   logic                        rsp_vld_ff, rsp_vld_in;
   rsp_payload_type             rsp_ff, rsp_in;
   logic                        rsp_load;

   logic                        mem_we, mem_re;
   logic [IDX_W-1:0]            mem_waddr, mem_raddr;
   logic [ENTRY_W-1:0]          mem_wdata, mem_rdata;

   logic signed [COORD_BITS-1:0] e_min_x, e_min_y, e_max_x, e_max_y;
   logic [ID_W-1:0]             e_owner;
   logic                        e_bnd;

   logic signed [ADD_W-1:0]     add_a, add_b;
   logic signed [ADD_W-1:0]     px_ext, py_ext, w_ext, h_ext, size_ext;
   logic signed [ADD_W-1:0]     box_ext [4];
   logic signed [COORD_BITS-1:0] add_sum;
   logic                        add_sat;
   logic                        ovl_hit;

   logic req_fire, out_free, more_rd, stg_match, is_move, is_add, is_query;
   logic scan_hit, scan_stall, table_full;

   // Table entry fields as they come out of the read port.
   assign e_min_x = mem_rdata[COORD_BITS-1:0];
   assign e_min_y = mem_rdata[2*COORD_BITS-1:COORD_BITS];
   assign e_max_x = mem_rdata[3*COORD_BITS-1:2*COORD_BITS];
   assign e_max_y = mem_rdata[4*COORD_BITS-1:3*COORD_BITS];
   assign e_owner = mem_rdata[BND_BIT-1:OWN_LSB];
   assign e_bnd   = mem_rdata[BND_BIT];

   aabbct_table_mem #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (ENTRY_W),
      .AW    (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   aabbct_sat_add #(
      .COORD_BITS (COORD_BITS),
      .ADD_W      (ADD_W)
   ) u_add (
      .op_a (add_a),
      .op_b (add_b),
      .sum  (add_sum),
      .sat  (add_sat)
   );

   aabbct_overlap #(
      .COORD_BITS (COORD_BITS)
   ) u_ovl (
      .a_min_x (box_ff[0]),
      .a_min_y (box_ff[1]),
      .a_max_x (box_ff[2]),
      .a_max_y (box_ff[3]),
      .b_min_x (e_min_x),
      .b_min_y (e_min_y),
      .b_max_x (e_max_x),
      .b_max_y (e_max_y),
      .hit     (ovl_hit)
   );

   assign px_ext   = {{(ADD_W-POS_W){req_ff.pos_x[POS_W-1]}}, req_ff.pos_x};
   assign py_ext   = {{(ADD_W-POS_W){req_ff.pos_y[POS_W-1]}}, req_ff.pos_y};
   assign w_ext    = {{(ADD_W-DIM_W){1'b0}}, req_ff.box_width};
   assign h_ext    = {{(ADD_W-DIM_W){1'b0}}, req_ff.box_height};
   assign size_ext = {{(ADD_W-SIZE_W){1'b0}}, size_ff};

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         box_ext[i] = {{(ADD_W-COORD_BITS){box_ff[i][COORD_BITS-1]}}, box_ff[i]};
      end
   end

   // Operand selection for the shared adder, one box corner per step.
   // Add and query clamp the point first, then extend it by the box size (add) or the query size.
   always_comb begin
      add_a = box_ext[step_ff];
      add_b = is_move ? (step_ff[0] ? py_ext : px_ext) : '0;
      if (!is_move) begin
         case (step_ff)
            2'd0: add_a = px_ext;
            2'd1: add_a = py_ext;
            2'd2: begin
               add_a = box_ext[0];
               add_b = is_query ? size_ext : w_ext;
            end
            default: begin
               add_a = box_ext[1];
               add_b = is_query ? size_ext : h_ext;
            end
         endcase
      end
   end

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign out_free   = !rsp_vld_ff || rsp_chan.ready;
   assign more_rd    = rd_idx_ff < count_ff;
   assign stg_match  = stg_vld_ff && (e_owner == req_ff.actor_id);
   assign is_move    = req_ff.action == ACT_MOVE;
   assign is_add     = req_ff.action == ACT_ADD;
   assign is_query   = req_ff.action == ACT_QUERY;
   assign scan_hit   = stg_vld_ff && ovl_hit && !(is_move && (stg_idx_ff == found_ff));
   assign scan_stall = scan_hit && !out_free;
   assign table_full = count_ff == CNT_W'(TABLE_DEPTH);

   assign req_chan.ready   = state_ff == ST_IDLE;
   assign rsp_chan.valid   = rsp_vld_ff;
   assign rsp_chan.payload = rsp_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_chan.payload.action) inside
                  ACT_ADD: state_in = table_full ? ST_DONE : ST_CALC;
                  ACT_MOVE, ACT_REMOVE: state_in = ST_SEARCH;
                  ACT_QUERY: state_in = ST_CALC;
               endcase
            end
         end
         ST_CALC: begin
            if (step_ff == 2'd3) begin
               state_in = is_query ? ST_SCAN : ST_STORE;
            end
         end
         ST_STORE: begin
            state_in = is_add ? ST_DONE : ST_SCAN;
         end
         ST_SEARCH: begin
            if (stg_match) begin
               state_in = is_move ? ST_CALC : ST_SHIFT;
            end else if (!more_rd && !stg_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            if (!scan_stall && !more_rd) begin
               state_in = ST_DONE;
            end
         end
         ST_SHIFT: begin
            if (!more_rd) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, table port and response controls.
   always_comb begin
      count_in   = count_ff;
      rd_idx_in  = rd_idx_ff;
      stg_idx_in = stg_idx_ff;
      stg_vld_in = stg_vld_ff;
      found_in   = found_ff;
      step_in    = step_ff;
      sat_in     = sat_ff;
      status_in  = status_ff;
      req_in     = req_ff;
      mbnd_in    = mbnd_ff;
      for (int i = 0; i < 4; i++) begin
         box_in[i] = box_ff[i];
      end
      mem_we    = 1'b0;
      mem_waddr = found_ff;
      mem_wdata = {is_add ? req_ff.is_boundary : mbnd_ff, req_ff.actor_id,
                   box_ff[3], box_ff[2], box_ff[1], box_ff[0]};
      mem_re    = 1'b0;
      mem_raddr = rd_idx_ff[IDX_W-1:0];
      rsp_load  = 1'b0;
      rsp_in    = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               req_in     = req_chan.payload;
               step_in    = 2'd0;
               sat_in     = 1'b0;
               rd_idx_in  = '0;
               stg_vld_in = 1'b0;
               status_in  = (req_chan.payload.action == ACT_ADD && table_full) ?
                            STAT_FULL : STAT_OK;
            end
         end
         ST_CALC: begin
            box_in[step_ff] = add_sum;
            sat_in          = sat_ff | add_sat;
            step_in         = step_ff + 2'd1;
            rd_idx_in       = '0;
            stg_vld_in      = 1'b0;
         end
         ST_STORE: begin
            mem_we = 1'b1;
            if (is_add) begin
               mem_waddr = count_ff[IDX_W-1:0];
               count_in  = count_ff + 1'b1;
            end
         end
         ST_SEARCH: begin
            if (stg_match) begin
               found_in   = stg_idx_ff;
               box_in[0]  = e_min_x;
               box_in[1]  = e_min_y;
               box_in[2]  = e_max_x;
               box_in[3]  = e_max_y;
               mbnd_in    = e_bnd;
               step_in    = 2'd0;
               rd_idx_in  = CNT_W'(stg_idx_ff) + 1'b1;
               stg_vld_in = 1'b0;
            end else if (more_rd) begin
               mem_re     = 1'b1;
               rd_idx_in  = rd_idx_ff + 1'b1;
               stg_idx_in = rd_idx_ff[IDX_W-1:0];
               stg_vld_in = 1'b1;
            end else begin
               stg_vld_in = 1'b0;
               if (!stg_vld_ff) begin
                  status_in = STAT_NOT_FOUND;
               end
            end
         end
         ST_SCAN: begin
            if (!scan_stall) begin
               if (scan_hit) begin
                  rsp_load             = 1'b1;
                  rsp_in.kind          = is_move ? KIND_COLLISION : KIND_HIT;
                  rsp_in.moved_id      = is_move ? req_ff.actor_id : '0;
                  rsp_in.hit_id        = e_owner;
                  rsp_in.move_dx       = is_move ? req_ff.pos_x : '0;
                  rsp_in.move_dy       = is_move ? req_ff.pos_y : '0;
                  rsp_in.with_boundary = is_move && (mbnd_ff || e_bnd);
                  rsp_in.status        = STAT_OK;
                  rsp_in.last          = 1'b0;
               end
               if (more_rd) begin
                  mem_re     = 1'b1;
                  rd_idx_in  = rd_idx_ff + 1'b1;
                  stg_idx_in = rd_idx_ff[IDX_W-1:0];
                  stg_vld_in = 1'b1;
               end else begin
                  stg_vld_in = 1'b0;
               end
            end
         end
         ST_SHIFT: begin
            // Each entry read from above the removed one is written one slot down.
            if (stg_vld_ff) begin
               mem_we    = 1'b1;
               mem_waddr = stg_idx_ff - 1'b1;
               mem_wdata = mem_rdata;
            end
            if (more_rd) begin
               mem_re     = 1'b1;
               rd_idx_in  = rd_idx_ff + 1'b1;
               stg_idx_in = rd_idx_ff[IDX_W-1:0];
               stg_vld_in = 1'b1;
            end else begin
               stg_vld_in = 1'b0;
               count_in   = count_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_load             = 1'b1;
               rsp_in.kind          = KIND_DONE;
               rsp_in.moved_id      = '0;
               rsp_in.hit_id        = '0;
               rsp_in.move_dx       = '0;
               rsp_in.move_dy       = '0;
               rsp_in.with_boundary = 1'b0;
               rsp_in.status        = (status_ff != STAT_OK) ? status_ff :
                                      (sat_ff ? STAT_SATURATED : STAT_OK);
               rsp_in.last          = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_vld_in = rsp_load || (rsp_vld_ff && !rsp_chan.ready);
   assign size_in    = csr_write_en ? csr_write_data : size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         stg_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         size_ff    <= QUERY_SIZE_RESET;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         stg_vld_ff <= stg_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         size_ff    <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_idx_in;
      stg_idx_ff <= stg_idx_in;
      found_ff   <= found_in;
      step_ff    <= step_in;
      sat_ff     <= sat_in;
      status_ff  <= status_in;
      req_ff     <= req_in;
      mbnd_ff    <= mbnd_in;
      rsp_ff     <= rsp_in;
      for (int i = 0; i < 4; i++) begin
         box_ff[i] <= box_in[i];
      end
   end

endmodule

>>> src/aabbct_table_mem.sv
// Box table storage: one write port and one read port with registered read
// data. Stand-alone; no package needed.
`timescale 1ns / 1ps

module aabbct_table_mem #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 81,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/aabbct_sat_add.sv
// Shared saturating adder: adds two sign-extended operands and clamps the
// sum to the signed coordinate range. Stand-alone; no package needed.
`timescale 1ns / 1ps

module aabbct_sat_add #(
   parameter int COORD_BITS = 16,
   parameter int ADD_W      = 18
) (
   input  logic signed [ADD_W-1:0]      op_a,
   input  logic signed [ADD_W-1:0]      op_b,
   output logic signed [COORD_BITS-1:0] sum,
   output logic                         sat
);

   localparam logic signed [ADD_W-1:0] HI =
      {{(ADD_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [ADD_W-1:0] LO =
      {{(ADD_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

   logic signed [ADD_W-1:0] raw;

   assign raw = op_a + op_b;

   always_comb begin
      sat = 1'b0;
      sum = raw[COORD_BITS-1:0];
      if (raw > HI) begin
         sat = 1'b1;
         sum = HI[COORD_BITS-1:0];
      end else if (raw < LO) begin
         sat = 1'b1;
         sum = LO[COORD_BITS-1:0];
      end
   end

endmodule

>>> src/aabbct_overlap.sv
// Strict overlap test between the working box and one stored table entry.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module aabbct_overlap #(
   parameter int COORD_BITS = 16
) (
   input  logic signed [COORD_BITS-1:0] a_min_x,
   input  logic signed [COORD_BITS-1:0] a_min_y,
   input  logic signed [COORD_BITS-1:0] a_max_x,
   input  logic signed [COORD_BITS-1:0] a_max_y,
   input  logic signed [COORD_BITS-1:0] b_min_x,
   input  logic signed [COORD_BITS-1:0] b_min_y,
   input  logic signed [COORD_BITS-1:0] b_max_x,
   input  logic signed [COORD_BITS-1:0] b_max_y,
   output logic                         hit
);

   // Touching edges do not count as an overlap.
   assign hit = (a_min_x < b_max_x) && (a_max_x > b_min_x) &&
                (a_min_y < b_max_y) && (a_max_y > b_min_y);

endmodule
